>>> sv/urtb_pkg.sv
// ----------------------------------------------------------------------------
// urtb_pkg
// Shared types and constants for the UART receive/transmit ring buffers.
// ----------------------------------------------------------------------------
package urtb_pkg;

  localparam int DEPTH   = 128;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int BYTE_W  = 8;
  localparam int LEVEL_W = 8;

  localparam logic [BYTE_W-1:0] CHAR_STOP  = 8'h54;  // 'T'
  localparam logic [BYTE_W-1:0] CHAR_CLOSE = 8'h43;  // 'C'

  typedef enum logic [1:0] {
    FUNC_RX_BYTE  = 2'd0,
    FUNC_TX_READY = 2'd1,
    FUNC_SW_READ  = 2'd2,
    FUNC_SW_WRITE = 2'd3
  } urtb_func_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic               tx_valid;
    logic [BYTE_W-1:0]  tx_byte;
    logic               read_valid;
    logic [BYTE_W-1:0]  read_byte;
    logic               put_accepted;
    logic               tx_kick;
    logic               rx_dropped;
    logic               reset_request;
    logic               kill_flag;
    logic [LEVEL_W-1:0] rx_level;
    logic [LEVEL_W-1:0] tx_level;
  } out_item_t;

  // Outcome of one event, handed from the pointer control to the result stage
  typedef struct packed {
    logic               valid;
    logic               tx_pop;
    logic               rx_pop;
    logic               put_accepted;
    logic               tx_kick;
    logic               rx_dropped;
    logic               reset_request;
    logic               kill_flag;
    logic [LEVEL_W-1:0] rx_level;
    logic [LEVEL_W-1:0] tx_level;
  } evt_t;

endpackage

>>> sv/urtb_ram.sv
// ----------------------------------------------------------------------------
// urtb_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module urtb_ram #(
  parameter int WORDS  = 128,
  parameter int DATA_W = 8,
  parameter int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [WORDS];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/urtb_ctrl.sv
// ----------------------------------------------------------------------------
// urtb_ctrl
// Pointer, fill count and flag control for both rings; issues RAM accesses.
// ----------------------------------------------------------------------------
module urtb_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  urtb_pkg::in_item_t        in_data,
  output logic                      rx_we,
  output logic [urtb_pkg::ADDR_W-1:0] rx_waddr,
  output logic                      rx_re,
  output logic [urtb_pkg::ADDR_W-1:0] rx_raddr,
  output logic                      tx_we,
  output logic [urtb_pkg::ADDR_W-1:0] tx_waddr,
  output logic                      tx_re,
  output logic [urtb_pkg::ADDR_W-1:0] tx_raddr,
  output logic [urtb_pkg::BYTE_W-1:0] wdata,
  output urtb_pkg::evt_t            evt_nxt
);
  import urtb_pkg::*;

  logic [ADDR_W-1:0] rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt;
  logic [ADDR_W-1:0] tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt;
  logic [CNT_W-1:0]  rx_fill_r, rx_fill_nxt, tx_fill_r, tx_fill_nxt;
  logic              tx_running_r, tx_running_nxt;
  logic              kill_r, kill_nxt;
  logic              ready_r;
  logic              accept;
  logic              rx_full, tx_full;
  urtb_func_t        func;

  function automatic logic [ADDR_W-1:0] next_pos(input logic [ADDR_W-1:0] p);
    next_pos = (p == ADDR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign busy     = !ready_r;
  assign accept   = start && ready_r;
  assign func     = urtb_func_t'(in_data.func);
  assign rx_full  = (rx_fill_r == CNT_W'(DEPTH));
  assign tx_full  = (tx_fill_r == CNT_W'(DEPTH));
  assign rx_waddr = rx_head_r;
  assign rx_raddr = rx_tail_r;
  assign tx_waddr = tx_head_r;
  assign tx_raddr = tx_tail_r;
  assign wdata    = in_data.data_byte;

  always_comb begin
    rx_head_nxt    = rx_head_r;
    rx_tail_nxt    = rx_tail_r;
    rx_fill_nxt    = rx_fill_r;
    tx_head_nxt    = tx_head_r;
    tx_tail_nxt    = tx_tail_r;
    tx_fill_nxt    = tx_fill_r;
    tx_running_nxt = tx_running_r;
    kill_nxt       = kill_r;
    rx_we          = 1'b0;
    rx_re          = 1'b0;
    tx_we          = 1'b0;
    tx_re          = 1'b0;
    evt_nxt        = '0;
    evt_nxt.valid  = accept;
    if (accept) begin
      unique case (func)
        FUNC_RX_BYTE: begin
          kill_nxt = (in_data.data_byte != CHAR_STOP);
          if (in_data.data_byte == CHAR_CLOSE) begin
            evt_nxt.reset_request = 1'b1;
            rx_head_nxt    = '0;
            rx_tail_nxt    = '0;
            rx_fill_nxt    = '0;
            tx_head_nxt    = '0;
            tx_tail_nxt    = '0;
            tx_fill_nxt    = '0;
            tx_running_nxt = 1'b0;
          end else if (!rx_full) begin
            rx_we       = 1'b1;
            rx_head_nxt = next_pos(rx_head_r);
            rx_fill_nxt = rx_fill_r + 1'b1;
          end else begin
            evt_nxt.rx_dropped = 1'b1;
          end
        end
        FUNC_TX_READY: begin
          if (tx_fill_r != '0) begin
            tx_re          = 1'b1;
            evt_nxt.tx_pop = 1'b1;
            tx_tail_nxt    = next_pos(tx_tail_r);
            tx_fill_nxt    = tx_fill_r - 1'b1;
          end else begin
            tx_running_nxt = 1'b0;
          end
        end
        FUNC_SW_READ: begin
          if (rx_fill_r != '0) begin
            rx_re          = 1'b1;
            evt_nxt.rx_pop = 1'b1;
            rx_tail_nxt    = next_pos(rx_tail_r);
            rx_fill_nxt    = rx_fill_r - 1'b1;
          end
        end
        FUNC_SW_WRITE: begin
          if (!tx_full) begin
            tx_we                = 1'b1;
            tx_head_nxt          = next_pos(tx_head_r);
            tx_fill_nxt          = tx_fill_r + 1'b1;
            evt_nxt.put_accepted = 1'b1;
            if (!tx_running_r) begin
              tx_running_nxt  = 1'b1;
              evt_nxt.tx_kick = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    evt_nxt.kill_flag = kill_nxt;
    evt_nxt.rx_level  = LEVEL_W'(rx_fill_nxt);
    evt_nxt.tx_level  = LEVEL_W'(tx_fill_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_head_r    <= '0;
      rx_tail_r    <= '0;
      rx_fill_r    <= '0;
      tx_head_r    <= '0;
      tx_tail_r    <= '0;
      tx_fill_r    <= '0;
      tx_running_r <= 1'b0;
      kill_r       <= 1'b1;
      ready_r      <= 1'b0;
    end else begin
      rx_head_r    <= rx_head_nxt;
      rx_tail_r    <= rx_tail_nxt;
      rx_fill_r    <= rx_fill_nxt;
      tx_head_r    <= tx_head_nxt;
      tx_tail_r    <= tx_tail_nxt;
      tx_fill_r    <= tx_fill_nxt;
      tx_running_r <= tx_running_nxt;
      kill_r       <= kill_nxt;
      ready_r      <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_rx_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rx_fill_r <= CNT_W'(DEPTH))
    else $error("rx fill count beyond depth");

  a_tx_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tx_fill_r <= CNT_W'(DEPTH))
    else $error("tx fill count beyond depth");

  a_rx_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (rx_fill_r == '0) |-> (rx_head_r == rx_tail_r))
    else $error("rx ring empty but pointers differ");

  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    evt_nxt.reset_request |=> (rx_fill_r == '0 && tx_fill_r == '0 && !tx_running_r))
    else $error("close byte did not clear both rings");
`endif

endmodule

>>> sv/urtb_resp.sv
// ----------------------------------------------------------------------------
// urtb_resp
// Result stage: registers the event outcome and merges the RAM read data.
// ----------------------------------------------------------------------------
module urtb_resp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  urtb_pkg::evt_t              evt_nxt,
  input  logic [urtb_pkg::BYTE_W-1:0] rx_rdata,
  input  logic [urtb_pkg::BYTE_W-1:0] tx_rdata,
  output logic                        out_valid,
  output urtb_pkg::out_item_t         out_data
);
  import urtb_pkg::*;

  evt_t evt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      evt_r <= '0;
    end else begin
      evt_r <= evt_nxt;
    end
  end

  // read data lands in the same cycle as the registered outcome
  always_comb begin
    out_valid              = evt_r.valid;
    out_data.tx_valid      = evt_r.tx_pop;
    out_data.tx_byte       = evt_r.tx_pop ? tx_rdata : '0;
    out_data.read_valid    = evt_r.rx_pop;
    out_data.read_byte     = evt_r.rx_pop ? rx_rdata : '0;
    out_data.put_accepted  = evt_r.put_accepted;
    out_data.tx_kick       = evt_r.tx_kick;
    out_data.rx_dropped    = evt_r.rx_dropped;
    out_data.reset_request = evt_r.reset_request;
    out_data.kill_flag     = evt_r.kill_flag;
    out_data.rx_level      = evt_r.rx_level;
    out_data.tx_level      = evt_r.tx_level;
  end

`ifndef SYNTHESIS
  a_kick_needs_put: assert property (@(posedge clk) disable iff (!rst_n)
    out_data.tx_kick |-> out_data.put_accepted)
    else $error("kick without accepted write");

  a_single_action: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({out_data.tx_valid, out_data.read_valid, out_data.put_accepted,
              out_data.rx_dropped, out_data.reset_request}))
    else $error("more than one action in one result");

  a_flags_need_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !(out_data.tx_valid || out_data.read_valid || out_data.put_accepted))
    else $error("action flag outside a result cycle");
`endif

endmodule

>>> sv/uart_rx_tx_ring_buffers_core.sv
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers_core
// Receive and transmit byte rings between a UART and software.
// Result: registered, strobed in the cycle after the transfer of an event.
// Throughput: one event per cycle; both rings are single RAMs with one write
// and one registered read port, and an event touches at most one ring entry.
// Reset: synchronous, active low; pointers and counts clear, kill flag set,
// busy held high for the first cycle after reset. The receiver cannot stall.
// ----------------------------------------------------------------------------
module uart_rx_tx_ring_buffers_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  urtb_pkg::in_item_t  in_data,
  output logic                out_valid,
  output urtb_pkg::out_item_t out_data
);
  import urtb_pkg::*;

  logic              rx_we, rx_re, tx_we, tx_re;
  logic [ADDR_W-1:0] rx_waddr, rx_raddr, tx_waddr, tx_raddr;
  logic [BYTE_W-1:0] wdata, rx_rdata, tx_rdata;
  evt_t              evt_nxt;

  urtb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .rx_we    (rx_we),
    .rx_waddr (rx_waddr),
    .rx_re    (rx_re),
    .rx_raddr (rx_raddr),
    .tx_we    (tx_we),
    .tx_waddr (tx_waddr),
    .tx_re    (tx_re),
    .tx_raddr (tx_raddr),
    .wdata    (wdata),
    .evt_nxt  (evt_nxt)
  );

  urtb_ram #(
    .WORDS  (DEPTH),
    .DATA_W (BYTE_W),
    .ADDR_W (ADDR_W)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_waddr),
    .wdata (wdata),
    .re    (rx_re),
    .raddr (rx_raddr),
    .rdata (rx_rdata)
  );

  urtb_ram #(
    .WORDS  (DEPTH),
    .DATA_W (BYTE_W),
    .ADDR_W (ADDR_W)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_waddr),
    .wdata (wdata),
    .re    (tx_re),
    .raddr (tx_raddr),
    .rdata (tx_rdata)
  );

  urtb_resp u_resp (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt_nxt   (evt_nxt),
    .rx_rdata  (rx_rdata),
    .tx_rdata  (tx_rdata),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> tb/urtb_ring_checker.sv
// ----------------------------------------------------------------------------
// urtb_ring_checker
// Watches both channels of the ring buffer core, keeps its own copy of the
// two rings, predicts the outcome of every accepted event and compares each
// strobed result, field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module urtb_ring_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  urtb_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  urtb_pkg::out_item_t out_data,
  output int                  errors,
  output int                  outstanding
);

  import urtb_pkg::*;

  logic [BYTE_W-1:0] rx_ring [DEPTH];
  logic [BYTE_W-1:0] tx_ring [DEPTH];
  int                rx_wr, rx_rd, rx_fill;
  int                tx_wr, tx_rd, tx_fill;
  logic              tx_running;
  logic              kill_state;

  out_item_t         awaited_outcomes [$];
  out_item_t         want;
  int                result_no;

  function automatic int wrap_inc(int p);
    return (p + 1 >= DEPTH) ? 0 : p + 1;
  endfunction

  function automatic void clear_rings();
    rx_wr = 0; rx_rd = 0; rx_fill = 0;
    tx_wr = 0; tx_rd = 0; tx_fill = 0;
    tx_running = 1'b0;
  endfunction

  function automatic out_item_t predict_event(in_item_t ev);
    out_item_t r;
    r = '0;
    case (urtb_func_t'(ev.func))
      FUNC_RX_BYTE: begin
        kill_state = (ev.data_byte == CHAR_STOP) ? 1'b0 : 1'b1;
        if (ev.data_byte == CHAR_CLOSE) begin
          r.reset_request = 1'b1;
          clear_rings();
        end else if (rx_fill < DEPTH) begin
          rx_ring[rx_wr] = ev.data_byte;
          rx_wr = wrap_inc(rx_wr);
          rx_fill++;
        end else begin
          r.rx_dropped = 1'b1;
        end
      end
      FUNC_TX_READY: begin
        if (tx_fill != 0) begin
          r.tx_valid = 1'b1;
          r.tx_byte  = tx_ring[tx_rd];
          tx_rd = wrap_inc(tx_rd);
          tx_fill--;
        end else begin
          tx_running = 1'b0;
        end
      end
      FUNC_SW_READ: begin
        if (rx_fill != 0) begin
          r.read_valid = 1'b1;
          r.read_byte  = rx_ring[rx_rd];
          rx_rd = wrap_inc(rx_rd);
          rx_fill--;
        end
      end
      default: begin
        if (tx_fill < DEPTH) begin
          tx_ring[tx_wr] = ev.data_byte;
          tx_wr = wrap_inc(tx_wr);
          tx_fill++;
          r.put_accepted = 1'b1;
          // kick only when the transmitter had gone idle
          if (!tx_running) begin
            tx_running = 1'b1;
            r.tx_kick  = 1'b1;
          end
        end
      end
    endcase
    r.kill_flag = kill_state;
    r.rx_level  = LEVEL_W'(rx_fill);
    r.tx_level  = LEVEL_W'(tx_fill);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [BYTE_W-1:0] got,
                             logic [BYTE_W-1:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("result %0d %s: got %02h, expected %02h",
                                result_no, name, got, exp_val));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_rings();
      kill_state = 1'b1;
      awaited_outcomes.delete();
      errors      = 0;
      result_no   = 0;
      outstanding <= 0;
    end else begin
      // a result always belongs to an earlier transfer, so compare first
      if (out_valid) begin
        if (awaited_outcomes.size() == 0) begin
          report_mismatch($sformatf("result %0d strobed with no event waiting",
                                    result_no));
        end else begin
          want = awaited_outcomes.pop_front();
          check_field("tx_valid",      out_data.tx_valid,      want.tx_valid);
          check_field("tx_byte",       out_data.tx_byte,       want.tx_byte);
          check_field("read_valid",    out_data.read_valid,    want.read_valid);
          check_field("read_byte",     out_data.read_byte,     want.read_byte);
          check_field("put_accepted",  out_data.put_accepted,  want.put_accepted);
          check_field("tx_kick",       out_data.tx_kick,       want.tx_kick);
          check_field("rx_dropped",    out_data.rx_dropped,    want.rx_dropped);
          check_field("reset_request", out_data.reset_request, want.reset_request);
          check_field("kill_flag",     out_data.kill_flag,     want.kill_flag);
          check_field("rx_level",      out_data.rx_level,      want.rx_level);
          check_field("tx_level",      out_data.tx_level,      want.tx_level);
        end
        result_no++;
      end
      if (start && !busy) awaited_outcomes.push_back(predict_event(in_data));
      outstanding <= awaited_outcomes.size();
    end
  end

endmodule

>>> tb/tb_uart_rx_tx_ring_buffers_core.sv
// ----------------------------------------------------------------------------
// tb_uart_rx_tx_ring_buffers_core
// Drives received bytes, transmitter-ready, software reads and writes into
// the ring buffer core: a directed opening, then random phases that flood,
// overflow, drain and clear both rings, sent in bursts with random gaps.
// ----------------------------------------------------------------------------
module tb_uart_rx_tx_ring_buffers_core;

  import urtb_pkg::*;

  localparam int EVENT_TARGET = 1820;
  localparam int CYCLE_LIMIT  = 200000;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_data = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_data;

  int        errors;
  int        outstanding;
  int        cycle_count = 0;
  int        sent        = 0;
  int        burst_left  = 0;

  always #5 clk = ~clk;

  uart_rx_tx_ring_buffers_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  urtb_ring_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(0, 255)); while (b == CHAR_CLOSE);
    return b;
  endfunction

  // burst pacing: start stays high inside a burst, drops for a random gap
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(0, 12);
      @(negedge clk) start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_event(urtb_func_t f, logic [BYTE_W-1:0] b);
    in_item_t item;
    item.func      = f;
    item.data_byte = b;
    @(negedge clk);
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy !== 1'b0);
    sent++;
    pace();
  endtask

  task automatic quiesce();
    @(negedge clk) start <= 1'b0;
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int n;
    int pick;
    bit paused;
    paused = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed opening: refusals on empty rings, kicks, extremes, stop and close
    send_event(FUNC_SW_READ,  8'h00);
    send_event(FUNC_TX_READY, 8'hFF);
    send_event(FUNC_SW_WRITE, 8'h00);
    send_event(FUNC_SW_WRITE, 8'hFF);
    send_event(FUNC_TX_READY, 8'h00);
    send_event(FUNC_TX_READY, 8'h00);
    send_event(FUNC_TX_READY, 8'h00);
    send_event(FUNC_SW_WRITE, 8'hA5);
    send_event(FUNC_RX_BYTE,  8'h00);
    send_event(FUNC_RX_BYTE,  8'hFF);
    send_event(FUNC_RX_BYTE,  CHAR_STOP);
    send_event(FUNC_SW_READ,  8'hFF);
    send_event(FUNC_SW_READ,  8'h00);
    send_event(FUNC_RX_BYTE,  8'h5A);
    send_event(FUNC_SW_READ,  8'h00);
    send_event(FUNC_SW_WRITE, 8'h3C);
    send_event(FUNC_RX_BYTE,  CHAR_CLOSE);
    send_event(FUNC_TX_READY, 8'h00);
    send_event(FUNC_SW_READ,  8'h00);
    send_event(FUNC_SW_WRITE, 8'h81);
    send_event(FUNC_RX_BYTE,  CHAR_STOP);
    send_event(FUNC_RX_BYTE,  CHAR_CLOSE);

    while (sent < EVENT_TARGET) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          n = $urandom_range(20, 80);
          repeat (n) begin
            pick = $urandom_range(0, 39);
            if (pick == 0)      send_event(FUNC_RX_BYTE, CHAR_CLOSE);
            else if (pick == 1) send_event(FUNC_RX_BYTE, CHAR_STOP);
            else send_event(urtb_func_t'($urandom_range(0, 3)),
                            BYTE_W'($urandom_range(0, 255)));
          end
        end
        2: begin
          // fill the receive ring past full so bytes get dropped
          n = $urandom_range(100, 170);
          repeat (n) begin
            if ($urandom_range(0, 99) < 85) send_event(FUNC_RX_BYTE, plain_byte());
            else send_event(FUNC_SW_READ, BYTE_W'($urandom_range(0, 255)));
          end
        end
        3: begin
          // fill the transmit ring past full so writes get refused
          n = $urandom_range(100, 170);
          repeat (n) begin
            if ($urandom_range(0, 99) < 85)
              send_event(FUNC_SW_WRITE, BYTE_W'($urandom_range(0, 255)));
            else send_event(FUNC_TX_READY, BYTE_W'($urandom_range(0, 255)));
          end
        end
        4: begin
          n = $urandom_range(40, 140);
          repeat (n) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)      send_event(FUNC_SW_WRITE, plain_byte());
            else if (pick == 1) send_event(FUNC_RX_BYTE, plain_byte());
            else if (pick < 6)  send_event(FUNC_SW_READ, BYTE_W'($urandom_range(0, 255)));
            else send_event(FUNC_TX_READY, BYTE_W'($urandom_range(0, 255)));
          end
        end
        default: begin
          send_event(FUNC_RX_BYTE, CHAR_CLOSE);
          repeat ($urandom_range(2, 10))
            send_event(urtb_func_t'($urandom_range(0, 3)), plain_byte());
        end
      endcase
      if (!paused && sent > EVENT_TARGET / 2) begin
        quiesce();
        paused = 1'b1;
      end
    end

    quiesce();
    repeat (4) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/urtb_pkg.sv
sv/urtb_ram.sv
sv/urtb_ctrl.sv
sv/urtb_resp.sv
sv/uart_rx_tx_ring_buffers_core.sv
tb/urtb_ring_checker.sv
tb/tb_uart_rx_tx_ring_buffers_core.sv
